FILE: hdl/assert_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, held off while reset is low.
`define ASSERT_RST(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/cbor_hdr_pkg.sv
package cbor_hdr_pkg;

  // Result status codes.
  typedef enum logic [2:0] {
    StOk          = 3'd0,
    StBadType     = 3'd1,
    StNonShortest = 3'd2,
    StReserved    = 3'd3,
    StTruncated   = 3'd4,
    StBadSimple   = 3'd5,
    StOverflow    = 3'd6
  } status_e;

  // Major types that get special treatment.
  localparam logic [2:0] MajorUint   = 3'd0;
  localparam logic [2:0] MajorNegint = 3'd1;
  localparam logic [2:0] MajorTag    = 3'd6;
  localparam logic [2:0] MajorSimple = 3'd7;

  // Additional-info boundaries.
  localparam logic [4:0] InfoDirectMax   = 5'd23;
  localparam logic [4:0] InfoReservedMin = 5'd28;
  localparam logic [7:0] ShortestOneByte = 8'd24;

  // Simple values that are accepted.
  localparam logic [63:0] SimpleFalse = 64'd20;
  localparam logic [63:0] SimpleTrue  = 64'd21;

  localparam logic [3:0] MaxHeaderLen = 4'd9;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [2:0]         major_type;
    logic [63:0]        argument;
    logic signed [63:0] int_value;
    logic               bool_value;
    logic [3:0]         header_length;
  } out_item_t;

  // Header finished by the parser, before the type rules are applied.
  typedef struct packed {
    logic        emit;
    status_e     status;
    logic [2:0]  major_type;
    logic [63:0] argument;
    logic [3:0]  header_length;
  } hdr_t;

endpackage

FILE: hdl/cbor_hdr_parse.sv
`include "assert_macros.svh"

module cbor_hdr_parse (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  cbor_hdr_pkg::in_item_t item_i,
  output cbor_hdr_pkg::hdr_t     hdr_o
);

  logic [3:0]  bytes_left_q, bytes_left_d;
  logic [1:0]  size_code_q, size_code_d;
  logic [2:0]  major_q, major_d;
  logic [63:0] acc_q, acc_d;
  logic [3:0]  count_q, count_d;

  logic [2:0]  ib_major;
  logic [4:0]  ib_info;
  logic [63:0] acc_next;
  logic        shortest;

  assign ib_major = item_i.data_byte[7:5];
  assign ib_info  = item_i.data_byte[4:0];
  assign acc_next = {acc_q[55:0], item_i.data_byte};

  always_comb begin
    unique case (size_code_q)
      2'd0: shortest = (acc_next[7:0] >= cbor_hdr_pkg::ShortestOneByte);
      2'd1: shortest = (acc_next[15:8] != 8'd0);
      2'd2: shortest = (acc_next[31:16] != 16'd0);
      default: shortest = (acc_next[63:32] != 32'd0);
    endcase
  end

  always_comb begin
    bytes_left_d = bytes_left_q;
    size_code_d  = size_code_q;
    major_d      = major_q;
    acc_d        = acc_q;
    count_d      = count_q;

    hdr_o.emit          = 1'b0;
    hdr_o.status        = cbor_hdr_pkg::StOk;
    hdr_o.major_type    = major_q;
    hdr_o.argument      = 64'd0;
    hdr_o.header_length = count_q;

    if (step_i) begin
      if (item_i.end_of_data) begin
        // End marker inside a header: report truncation, start fresh.
        if (bytes_left_q != 4'd0) begin
          hdr_o.emit   = 1'b1;
          hdr_o.status = cbor_hdr_pkg::StTruncated;
          bytes_left_d = 4'd0;
          size_code_d  = 2'd0;
          major_d      = 3'd0;
          acc_d        = 64'd0;
          count_d      = 4'd0;
        end
      end else if (bytes_left_q == 4'd0) begin
        hdr_o.major_type    = ib_major;
        hdr_o.header_length = 4'd1;
        if (ib_major == cbor_hdr_pkg::MajorTag) begin
          hdr_o.emit   = 1'b1;
          hdr_o.status = cbor_hdr_pkg::StBadType;
        end else if (ib_info <= cbor_hdr_pkg::InfoDirectMax) begin
          hdr_o.emit     = 1'b1;
          hdr_o.argument = {59'd0, ib_info};
        end else if (ib_info >= cbor_hdr_pkg::InfoReservedMin) begin
          hdr_o.emit   = 1'b1;
          hdr_o.status = cbor_hdr_pkg::StReserved;
        end else begin
          // Info 24..27: low two bits pick 1, 2, 4 or 8 argument bytes.
          size_code_d  = ib_info[1:0];
          bytes_left_d = 4'd1 << ib_info[1:0];
          major_d      = ib_major;
          acc_d        = 64'd0;
          count_d      = 4'd1;
        end
      end else begin
        acc_d        = acc_next;
        count_d      = count_q + 4'd1;
        bytes_left_d = bytes_left_q - 4'd1;
        if (bytes_left_q == 4'd1) begin
          hdr_o.emit          = 1'b1;
          hdr_o.status        = shortest ? cbor_hdr_pkg::StOk : cbor_hdr_pkg::StNonShortest;
          hdr_o.argument      = acc_next;
          hdr_o.header_length = count_q + 4'd1;
          size_code_d         = 2'd0;
          major_d             = 3'd0;
          acc_d               = 64'd0;
          count_d             = 4'd0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bytes_left_q <= 4'd0;
      size_code_q  <= 2'd0;
      major_q      <= 3'd0;
      acc_q        <= 64'd0;
      count_q      <= 4'd0;
    end else begin
      bytes_left_q <= bytes_left_d;
      size_code_q  <= size_code_d;
      major_q      <= major_d;
      acc_q        <= acc_d;
      count_q      <= count_d;
    end
  end

  `ASSERT_RST(a_left_bounded, clk_i, rst_ni, bytes_left_q <= 4'd8, "argument byte count out of range")
  `ASSERT_RST(a_count_consistent, clk_i, rst_ni, (bytes_left_q != 4'd0) |-> (({1'b0, count_q} + {1'b0, bytes_left_q}) == (5'd1 + (5'd1 << size_code_q))), "consumed and remaining bytes disagree with size code")

endmodule

FILE: hdl/cbor_hdr_classify.sv
module cbor_hdr_classify (
  input  cbor_hdr_pkg::hdr_t      hdr_i,
  output cbor_hdr_pkg::out_item_t item_o
);

  cbor_hdr_pkg::status_e status;
  logic signed [63:0]    ival;
  logic                  bval;

  always_comb begin
    status = hdr_i.status;
    ival   = 64'sd0;
    bval   = 1'b0;
    if (hdr_i.status == cbor_hdr_pkg::StOk) begin
      if (hdr_i.major_type == cbor_hdr_pkg::MajorUint ||
          hdr_i.major_type == cbor_hdr_pkg::MajorNegint) begin
        if (hdr_i.argument[63]) begin
          status = cbor_hdr_pkg::StOverflow;
        end else if (hdr_i.major_type == cbor_hdr_pkg::MajorUint) begin
          ival = $signed(hdr_i.argument);
        end else begin
          // Negative integer: -1 - argument is the bitwise inverse.
          ival = $signed(~hdr_i.argument);
        end
      end else if (hdr_i.major_type == cbor_hdr_pkg::MajorSimple) begin
        if (hdr_i.argument == cbor_hdr_pkg::SimpleTrue) begin
          bval = 1'b1;
        end else if (hdr_i.argument != cbor_hdr_pkg::SimpleFalse) begin
          status = cbor_hdr_pkg::StBadSimple;
        end
      end
    end
  end

  assign item_o.status        = status;
  assign item_o.major_type    = hdr_i.major_type;
  assign item_o.argument      = hdr_i.argument;
  assign item_o.int_value     = ival;
  assign item_o.bool_value    = bval;
  assign item_o.header_length = hdr_i.header_length;

endmodule

FILE: hdl/cbor_header_decoder_core.sv
// CBOR item header decoder. Takes one stream byte (or an end-of-buffer
// marker) per request and returns one result request for every header
// that completes or is rejected: status, major type, raw argument, signed
// integer value for major types 0 and 1, and the true/false flag for
// simple values 20 and 21. Tags, reserved additional info 28..31,
// non-shortest arguments, other simple values (floats included) and
// integers of 2^63 or more are reported through the status. An end marker
// between headers produces nothing; inside a header it reports truncation.
// Throughput is one byte per clock while the result side is not stalling:
// a byte passes from the input register through the header parser and
// classifier into the result register combinationally, and the result is
// presented in the cycle after its last byte is taken. The input register
// takes a new byte whenever it is empty or moves on, so a waiting result
// never blocks intake for more than the one register slot; back-pressure on
// the result side stalls the parser while both registers hold data.
`include "assert_macros.svh"

module cbor_header_decoder_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  cbor_hdr_pkg::in_item_t  in_item_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output cbor_hdr_pkg::out_item_t out_item_o
);

  // Input register: holds one request until the parser takes it.
  logic                   in_valid_q;
  cbor_hdr_pkg::in_item_t in_item_q;

  // Result register.
  logic                    out_valid_q;
  cbor_hdr_pkg::out_item_t out_item_q;

  logic                    advance;
  logic                    step;
  cbor_hdr_pkg::hdr_t      hdr;
  cbor_hdr_pkg::out_item_t result;

  // Advance the parser whenever the result register is free or draining.
  assign advance    = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && advance;
  assign in_ready_o = !in_valid_q || advance;

  cbor_hdr_parse u_parse (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .item_i (in_item_q),
    .hdr_o  (hdr)
  );

  cbor_hdr_classify u_classify (
    .hdr_i  (hdr),
    .item_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // Load the next request or drop the consumed one.
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      // Capture a result only when the parser finished a header.
      if (advance) begin
        out_valid_q <= hdr.emit;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_item_q <= in_item_i;
    end
    if (advance && hdr.emit) begin
      out_item_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  `ASSERT_RST(a_len_range, clk_i, rst_ni, out_valid_o |-> (out_item_o.header_length != 4'd0 && out_item_o.header_length <= cbor_hdr_pkg::MaxHeaderLen), "header length out of range")
  `ASSERT_RST(a_bool_only_true, clk_i, rst_ni, (out_valid_o && out_item_o.bool_value) |-> (out_item_o.status == cbor_hdr_pkg::StOk && out_item_o.major_type == cbor_hdr_pkg::MajorSimple), "true flag on a non-simple or failed header")
  `ASSERT_RST(a_ival_only_int, clk_i, rst_ni, (out_valid_o && out_item_o.int_value != 64'sd0) |-> (out_item_o.status == cbor_hdr_pkg::StOk && (out_item_o.major_type == cbor_hdr_pkg::MajorUint || out_item_o.major_type == cbor_hdr_pkg::MajorNegint)), "integer value on a non-integer header")
  `ASSERT_ALWAYS(a_no_emit_without_step, clk_i, hdr.emit |-> step, "parser result without a byte taken")

endmodule
